// ===== rtl/core/dpns_pkg.sv =====
// shared constants and helpers for the diode pair newton solver
package dpns_pkg;

    localparam int NEWTON_STEPS = 12;
    localparam int BISECT_STEPS = 32;
    localparam int TAYLOR_TERMS = 13;
    localparam int CNT_W = $clog2((BISECT_STEPS > NEWTON_STEPS) ? BISECT_STEPS : NEWTON_STEPS);

    localparam int DIV_FRAC = 28;
    localparam int QW = DIV_FRAC + 3;
    localparam int MAG_W = 48;
    localparam int DER_W = 56;
    localparam int DIODE_W = 49;

    localparam logic signed [37:0] KP = 38'sd534441022;
    localparam logic signed [35:0] ISL2 = 36'sd258974295;
    localparam logic signed [35:0] EXP_BIAS = 36'sd2147483648;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [12:0] RK8 = 13'd5653;
    localparam logic [DIODE_W-1:0] DCAP = {1'b1, {(DIODE_W-1){1'b0}}};
    localparam logic signed [47:0] TOL = 48'sd176;
    localparam logic signed [31:0] V_LIMIT = 32'sd1073741824;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;

    // floor(2^36 / k) for the taylor term divides
    function automatic logic [35:0] recip_k(input logic [3:0] k);
        logic [35:0] r;
        begin
            case (k)
                4'd2:    r = 36'd34359738368;
                4'd3:    r = 36'd22906492245;
                4'd4:    r = 36'd17179869184;
                4'd5:    r = 36'd13743895347;
                4'd6:    r = 36'd11453246122;
                4'd7:    r = 36'd9817068105;
                4'd8:    r = 36'd8589934592;
                4'd9:    r = 36'd7635497415;
                4'd10:   r = 36'd6871947673;
                4'd11:   r = 36'd6247225157;
                4'd12:   r = 36'd5726623061;
                4'd13:   r = 36'd5286113595;
                default: r = 36'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] mid_point(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] s;
        begin
            s = 33'(a) + 33'(b);
            return s[32:1];
        end
    endfunction

endpackage

// ===== rtl/core/dpns_mul.sv =====
// shared signed multiplier with registered product
module dpns_mul
    import dpns_pkg::*;
(
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [37:0] b,
    output logic signed [70:0] prod
);

    logic signed [70:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 71'(a) * 71'(b);
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/dpns_div.sv =====
// restoring divider for the newton step, one quotient bit per cycle
module dpns_div
    import dpns_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MAG_W-1:0] mag,
    input  logic [DER_W-1:0] divisor,
    output logic [QW-1:0]    quo,
    output logic             done
);

    logic [DER_W-1:0] rem_reg;
    logic [DER_W-1:0] div_reg;
    logic [QW-1:0]    num_reg;
    logic [QW-1:0]    q_reg;
    logic [5:0]       cnt_reg;
    logic             run_reg;
    logic [DER_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, num_reg[QW-1]};
    assign ge = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            run_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg <= 6'(QW);
            run_reg <= 1'b1;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
        else
        begin
            run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DER_W'(mag >> (QW - DIV_FRAC));
            num_reg <= {mag[QW-DIV_FRAC-1:0], {DIV_FRAC{1'b0}}};
            div_reg <= divisor;
            q_reg   <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? DER_W'(trial - {1'b0, div_reg}) : trial[DER_W-1:0];
            num_reg <= {num_reg[QW-2:0], 1'b0};
            q_reg   <= {q_reg[QW-2:0], ge};
        end
    end

    assign quo  = q_reg;
    assign done = run_reg && (cnt_reg == '0);

endmodule

// ===== rtl/core/dpns_exp_shift.sv =====
// scales the q30 exponential mantissa by 2^i with saturation
module dpns_exp_shift
    import dpns_pkg::*;
(
    input  logic [31:0]        e,
    input  logic signed [11:0] i,
    output logic [DIODE_W-1:0] d
);

    logic [4:0]         sl;
    logic [11:0]        sr;
    logic [DIODE_W-1:0] sh;

    always_comb
    begin
        sl = '0;
        sr = '0;
        sh = '0;
        if (i > 12'sd47)
        begin
            d = DCAP;
        end
        else if (i >= 12'sd30)
        begin
            sl = 5'(i - 12'sd30);
            sh = {{(DIODE_W-32){1'b0}}, e} << sl;
            d  = (sh > DCAP) ? DCAP : sh;
        end
        else
        begin
            sr = 12'(12'sd30 - i);
            d  = (sr >= 12'd32) ? '0 : DIODE_W'(e >> sr[4:0]);
        end
    end

endmodule

// ===== rtl/core/diode_pair_newton_solver_unit.sv =====
// diode pair node solver: sequencer, state and residual datapath
// one residual evaluation suffices when the warm start already converges
// one item at a time: in_stall is high from acceptance until the result is registered
// the shared multiplier and the taylor series of the diode exponentials set the run time
// reset clears the stored voltage, the fallback count and all handshake state
module diode_pair_newton_solver_unit
    import dpns_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        conductance,
    input  logic signed [47:0] drive_current,
    input  logic [1:0]         negative_diodes,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] node_voltage,
    output logic signed [47:0] final_residual,
    output logic               used_bisection,
    output logic [31:0]        fallback_total
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PMUL  = 4'd1;
    localparam logic [3:0] S_PREG  = 4'd2;
    localparam logic [3:0] S_SIDE  = 4'd3;
    localparam logic [3:0] S_UREG  = 4'd4;
    localparam logic [3:0] S_TMUL  = 4'd5;
    localparam logic [3:0] S_TDIV  = 4'd6;
    localparam logic [3:0] S_TFIX  = 4'd7;
    localparam logic [3:0] S_SHIFT = 4'd8;
    localparam logic [3:0] S_GMUL  = 4'd9;
    localparam logic [3:0] S_RESID = 4'd10;
    localparam logic [3:0] S_DIV   = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0]               state_reg;
    logic signed [31:0]       v_reg, lo_reg, hi_reg, last_v_reg;
    logic [31:0]              g_reg;
    logic signed [47:0]       cur_reg;
    logic                     m2_reg;
    logic signed [60:0]       p_reg;
    logic signed [11:0]       i_reg;
    logic [29:0]              u_reg;
    logic [31:0]              e_reg;
    logic [30:0]              x_reg;
    logic [3:0]               k_reg;
    logic                     side_reg;
    logic [DIODE_W-1:0]       dp_reg, dn_reg;
    logic [DER_W-1:0]         d_reg;
    logic signed [47:0]       r_reg;
    logic                     bis_reg;
    logic [CNT_W-1:0]         it_reg;
    logic [31:0]              fb_reg;
    logic                     out_valid_reg;
    logic signed [31:0]       node_voltage_reg;
    logic signed [47:0]       final_residual_reg;
    logic                     used_bisection_reg;
    logic [31:0]              fallback_total_reg;

    logic signed [32:0]       mul_a;
    logic signed [37:0]       mul_b;
    logic signed [70:0]       prod;

    logic signed [60:0]       pz, zs;
    logic signed [35:0]       wb;
    logic signed [11:0]       i_w;
    logic [DIODE_W-1:0]       d_shift;
    logic [30:0]              x_t, q0, q_fix;
    logic [34:0]              q0k, x_rem;

    logic [61:0]              dpk, dnk;
    logic [DER_W-1:0]         d_next;
    logic signed [43:0]       gv;
    logic signed [50:0]       rsum;
    logic signed [47:0]       rs;
    logic                     conv, pos;
    logic signed [31:0]       lo_n, hi_n, mid_n, mid_b;
    logic [MAG_W-1:0]         mag;
    logic                     bad;
    logic                     div_start, div_done;
    logic [QW-1:0]            quo;
    logic signed [32:0]       nx;
    logic                     nx_in;
    logic                     accept, out_free;
    logic signed [31:0]       v_start;

    dpns_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    dpns_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .mag     (mag),
        .divisor (d_reg),
        .quo     (quo),
        .done    (div_done)
    );

    dpns_exp_shift u_shift (
        .e (e_reg),
        .i (i_reg),
        .d (d_shift)
    );

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // warm start, clamped to the solve range
    assign v_start = (last_v_reg < -V_LIMIT) ? -V_LIMIT :
                     (last_v_reg > V_LIMIT) ? V_LIMIT : last_v_reg;

    // exponent argument of the current diode side
    assign pz  = side_reg ? -p_reg : p_reg;
    assign zs  = (side_reg && m2_reg) ? (pz >>> 29) : (pz >>> 28);
    assign wb  = zs[35:0] + ISL2 + EXP_BIAS;
    assign i_w = signed'(wb[35:24]) - 12'sd128;

    // taylor term divide by k with a one step correction
    assign x_t   = prod[60:30];
    assign q0    = prod[66:36];
    assign q0k   = 35'(q0) * 35'(k_reg);
    assign x_rem = 35'(x_reg) - q0k;
    assign q_fix = (x_rem >= 35'(k_reg)) ? q0 + 31'd1 : q0;

    assign dpk    = 62'(dp_reg) * 62'(RK8);
    assign dnk    = 62'(dn_reg) * 62'(RK8);
    assign d_next = DER_W'({g_reg, 8'b0}) + DER_W'(dpk >> 8) +
                    DER_W'(m2_reg ? (dnk >> 9) : (dnk >> 8));

    assign gv   = prod[63:20];
    assign rsum = 51'(gv) + 51'(dp_reg) - 51'(dn_reg) - 51'(cur_reg);

    always_comb
    begin
        if (!rsum[50] && (rsum[49:47] != 3'b000))
        begin
            rs = {1'b0, {47{1'b1}}};
        end
        else if (rsum[50] && (rsum[49:47] != 3'b111))
        begin
            rs = {1'b1, {47{1'b0}}};
        end
        else
        begin
            rs = rsum[47:0];
        end
    end

    assign conv  = (rs > -TOL) && (rs < TOL);
    assign pos   = rs > 48'sd0;
    assign lo_n  = pos ? lo_reg : v_reg;
    assign hi_n  = pos ? v_reg : hi_reg;
    assign mid_n = mid_point(lo_n, hi_n);
    assign mid_b = mid_point(lo_reg, hi_reg);
    assign mag   = rs[47] ? MAG_W'(-rs) : MAG_W'(rs);
    assign bad   = (d_reg == '0) || ({11'b0, mag} >= {d_reg, 3'b0});

    assign div_start = (state_reg == S_RESID) && !bis_reg && !conv && !bad;

    assign nx    = (r_reg > 48'sd0) ? 33'(v_reg) - 33'(quo) : 33'(v_reg) + 33'(quo);
    assign nx_in = (nx > 33'(lo_reg)) && (nx < 33'(hi_reg));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_PMUL:
            begin
                mul_a = 33'(v_reg);
                mul_b = KP;
            end
            S_SIDE:
            begin
                mul_a = 33'(wb[23:0]);
                mul_b = 38'(LN2_Q30);
            end
            S_TMUL:
            begin
                mul_a = 33'(x_reg);
                mul_b = 38'(u_reg);
            end
            S_TDIV:
            begin
                mul_a = 33'(x_t);
                mul_b = 38'(recip_k(k_reg));
            end
            S_GMUL:
            begin
                mul_a = 33'(v_reg);
                mul_b = 38'(g_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_v_reg    <= '0;
            fb_reg        <= '0;
            out_valid_reg <= 1'b0;
            bis_reg       <= 1'b0;
            it_reg        <= '0;
            side_reg      <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        bis_reg   <= 1'b0;
                        it_reg    <= '0;
                        state_reg <= S_PMUL;
                    end
                end
                S_PMUL:
                begin
                    side_reg  <= 1'b0;
                    state_reg <= S_PREG;
                end
                S_PREG:
                begin
                    state_reg <= S_SIDE;
                end
                S_SIDE:
                begin
                    if (wb[35] || (i_w > 12'sd47))
                    begin
                        side_reg  <= 1'b1;
                        state_reg <= side_reg ? S_GMUL : S_SIDE;
                    end
                    else
                    begin
                        state_reg <= S_UREG;
                    end
                end
                S_UREG:
                begin
                    k_reg     <= 4'd1;
                    state_reg <= S_TMUL;
                end
                S_TMUL:
                begin
                    state_reg <= S_TDIV;
                end
                S_TDIV:
                begin
                    if (k_reg == 4'd1)
                    begin
                        k_reg     <= 4'd2;
                        state_reg <= S_TMUL;
                    end
                    else
                    begin
                        state_reg <= S_TFIX;
                    end
                end
                S_TFIX:
                begin
                    if (k_reg == 4'(TAYLOR_TERMS))
                    begin
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= S_TMUL;
                    end
                end
                S_SHIFT:
                begin
                    side_reg  <= 1'b1;
                    state_reg <= side_reg ? S_GMUL : S_SIDE;
                end
                S_GMUL:
                begin
                    state_reg <= S_RESID;
                end
                S_RESID:
                begin
                    if (bis_reg)
                    begin
                        if (it_reg == CNT_W'(BISECT_STEPS - 1))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            it_reg    <= it_reg + CNT_W'(1);
                            state_reg <= S_PMUL;
                        end
                    end
                    else if (conv)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (!bad)
                    begin
                        state_reg <= S_DIV;
                    end
                    else if (it_reg == CNT_W'(NEWTON_STEPS - 1))
                    begin
                        bis_reg   <= 1'b1;
                        it_reg    <= '0;
                        fb_reg    <= (fb_reg == '1) ? fb_reg : fb_reg + 32'd1;
                        state_reg <= S_PMUL;
                    end
                    else
                    begin
                        it_reg    <= it_reg + CNT_W'(1);
                        state_reg <= S_PMUL;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (it_reg == CNT_W'(NEWTON_STEPS - 1))
                        begin
                            bis_reg <= 1'b1;
                            it_reg  <= '0;
                            fb_reg  <= (fb_reg == '1) ? fb_reg : fb_reg + 32'd1;
                        end
                        else
                        begin
                            it_reg <= it_reg + CNT_W'(1);
                        end
                        state_reg <= S_PMUL;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        last_v_reg    <= v_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    g_reg   <= conductance;
                    cur_reg <= drive_current;
                    m2_reg  <= negative_diodes[1];
                    v_reg   <= v_start;
                    lo_reg  <= -V_LIMIT;
                    hi_reg  <= V_LIMIT;
                end
            end
            S_PREG:
            begin
                p_reg <= prod[60:0];
            end
            S_SIDE:
            begin
                i_reg <= i_w;
                if (wb[35] || (i_w > 12'sd47))
                begin
                    if (side_reg)
                    begin
                        dn_reg <= wb[35] ? '0 : DCAP;
                    end
                    else
                    begin
                        dp_reg <= wb[35] ? '0 : DCAP;
                    end
                end
            end
            S_UREG:
            begin
                u_reg <= prod[53:24];
                e_reg <= 32'(ONE_Q30);
                x_reg <= ONE_Q30;
            end
            S_TDIV:
            begin
                x_reg <= x_t;
                if (k_reg == 4'd1)
                begin
                    e_reg <= e_reg + 32'(x_t);
                end
            end
            S_TFIX:
            begin
                x_reg <= q_fix;
                e_reg <= e_reg + 32'(q_fix);
            end
            S_SHIFT:
            begin
                if (side_reg)
                begin
                    dn_reg <= d_shift;
                end
                else
                begin
                    dp_reg <= d_shift;
                end
            end
            S_GMUL:
            begin
                d_reg <= d_next;
            end
            S_RESID:
            begin
                r_reg <= rs;
                if (bis_reg)
                begin
                    lo_reg <= lo_n;
                    hi_reg <= hi_n;
                    if (it_reg != CNT_W'(BISECT_STEPS - 1))
                    begin
                        v_reg <= mid_n;
                    end
                end
                else if (!conv)
                begin
                    lo_reg <= lo_n;
                    hi_reg <= hi_n;
                    if (bad)
                    begin
                        v_reg <= mid_n;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (it_reg == CNT_W'(NEWTON_STEPS - 1))
                    begin
                        v_reg <= mid_b;
                    end
                    else
                    begin
                        v_reg <= nx_in ? nx[31:0] : mid_b;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    node_voltage_reg   <= v_reg;
                    final_residual_reg <= r_reg;
                    used_bisection_reg <= bis_reg;
                    fallback_total_reg <= fb_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign node_voltage   = node_voltage_reg;
    assign final_residual = final_residual_reg;
    assign used_bisection = used_bisection_reg;
    assign fallback_total = fallback_total_reg;

endmodule

// ===== rtl/core/dpns_checker.sv =====
// port level checks for the diode pair newton solver
module dpns_checker
    import dpns_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [31:0]        conductance,
    input logic signed [47:0] drive_current,
    input logic [1:0]         negative_diodes,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] node_voltage,
    input logic signed [47:0] final_residual,
    input logic               used_bisection,
    input logic [31:0]        fallback_total
);

    // busy after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("solver ready right after taking an item");

    // voltage stays inside the solve range
    a_voltage_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (node_voltage >= -V_LIMIT) && (node_voltage <= V_LIMIT))
        else $error("node voltage out of range");

    // newton results are converged
    a_newton_converged: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !used_bisection |-> (final_residual > -TOL) && (final_residual < TOL))
        else $error("newton result not converged");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled item dropped");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(node_voltage) && $stable(final_residual))
        else $error("stalled item changed");

endmodule

bind diode_pair_newton_solver_unit dpns_checker u_dpns_checker (.*);

// ===== dv/testbench.sv =====
// testbench for the diode pair newton solver: predicted results checked against the block
`timescale 1ns / 100ps

module testbench;
    import dpns_pkg::*;

    localparam longint KP_C = 64'sd534441022;
    localparam longint ISL2_C = 64'sd258974295;
    localparam longint unsigned LN2_C = 64'd744261118;
    localparam longint unsigned RK8_C = 64'd5653;
    localparam longint unsigned CAP_C = 64'd1 << 48;
    localparam longint TOL_C = 64'sd176;
    localparam longint VLIM_C = 64'sd1 << 30;
    localparam longint RMAX_C = (64'sd1 << 47) - 1;
    localparam longint RMIN_C = -(64'sd1 << 47);
    localparam int NEWTON_MAX = NEWTON_STEPS;
    localparam int BISECT_MAX = BISECT_STEPS;

    typedef struct packed {
        logic [31:0] g;
        logic signed [47:0] cur;
        logic [1:0] nd;
    } drive_item_t;

    typedef struct packed {
        logic signed [31:0] v;
        logic signed [47:0] r;
        logic bis;
        logic [31:0] total;
    } solution_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [31:0] conductance;
    logic signed [47:0] drive_current;
    logic [1:0] negative_diodes;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] node_voltage;
    logic signed [47:0] final_residual;
    logic used_bisection;
    logic [31:0] fallback_total;

    drive_item_t pending_items[$];
    solution_t expected_solutions[$];
    longint stored_voltage;
    logic [31:0] fallback_seen;
    int error_count;
    bit stimulus_done;
    int in_gap;
    int out_gap;

    diode_pair_newton_solver_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .conductance(conductance), .drive_current(drive_current),
        .negative_diodes(negative_diodes),
        .out_valid(out_valid), .out_stall(out_stall),
        .node_voltage(node_voltage), .final_residual(final_residual),
        .used_bisection(used_bisection), .fallback_total(fallback_total)
    );

    function automatic longint floor_shift(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint unsigned diode_current(longint z);
        longint wb;
        longint i;
        longint unsigned f, u, e, term;
        wb = z + ISL2_C + (64'sd128 << 24);
        if (wb < 0)
            return 0;
        i = (wb >>> 24) - 128;
        if (i > 47)
            return CAP_C;
        f = wb & 64'hFFFFFF;
        u = (f * LN2_C) >> 24;
        e = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 13; k++)
        begin
            term = ((term * u) >> 30) / k;
            e += term;
        end
        if (i >= 30)
        begin
            e = e << (i - 30);
            return (e > CAP_C) ? CAP_C : e;
        end
        if (30 - i > 62)
            return 0;
        return e >> (30 - i);
    endfunction

    function automatic longint node_residual(longint v, longint unsigned g, longint cur,
                                             int m, output longint unsigned slope);
        longint p, r;
        longint unsigned dp, dn;
        p = v * KP_C;
        dp = diode_current(floor_shift(p, 28));
        dn = diode_current(floor_shift(-p, 28 + m - 1));
        r = floor_shift(longint'(g) * v, 20) + longint'(dp) - longint'(dn) - cur;
        if (r > RMAX_C)
            r = RMAX_C;
        if (r < RMIN_C)
            r = RMIN_C;
        slope = (g << 8) + ((dp * RK8_C) >> 8) + ((dn * RK8_C) >> (8 + m - 1));
        return r;
    endfunction

    function automatic solution_t solve_node(drive_item_t it);
        solution_t s;
        longint lo, hi, v, r, cur, nxt;
        longint unsigned d, mag, q, g, rem;
        int m;
        bit done;
        g = it.g;
        cur = it.cur;
        m = (it.nd >= 2) ? 2 : 1;
        lo = -VLIM_C;
        hi = VLIM_C;
        v = stored_voltage;
        r = 0;
        done = 0;
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        for (int k = 0; k < NEWTON_MAX; k++)
        begin
            r = node_residual(v, g, cur, m, d);
            if (r > -TOL_C && r < TOL_C)
            begin
                done = 1;
                break;
            end
            if (r > 0)
                hi = v;
            else
                lo = v;
            mag = (r < 0) ? longint'(-r) : longint'(r);
            if (d == 0 || mag >= d * 8)
            begin
                v = floor_shift(lo + hi, 1);
                continue;
            end
            q = mag / d;
            rem = mag % d;
            for (int b = 0; b < 28; b++)
            begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= d)
                begin
                    rem -= d;
                    q |= 1;
                end
            end
            nxt = (r > 0) ? v - longint'(q) : v + longint'(q);
            v = (nxt > lo && nxt < hi) ? nxt : floor_shift(lo + hi, 1);
        end
        s.bis = !done;
        if (!done)
        begin
            if (fallback_seen != 32'hFFFFFFFF)
                fallback_seen++;
            for (int k = 0; k < BISECT_MAX; k++)
            begin
                v = floor_shift(lo + hi, 1);
                if (node_residual(v, g, cur, m, d) > 0)
                    hi = v;
                else
                    lo = v;
            end
            r = node_residual(v, g, cur, m, d);
        end
        stored_voltage = v;
        s.v = v[31:0];
        s.r = r[47:0];
        s.total = fallback_seen;
        return s;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    function automatic drive_item_t random_item();
        drive_item_t it;
        int sel;
        sel = $urandom_range(0, 9);
        it.nd = 2'($urandom_range(0, 3));
        case (sel)
            0: it.g = $urandom;
            1, 2: it.g = $urandom_range(0, 4095);
            default: it.g = $urandom_range(0, 1 << 24);
        endcase
        sel = $urandom_range(0, 9);
        case (sel)
            0: it.cur = 48'({$urandom, $urandom} >> 16);
            1: it.cur = $signed(48'($urandom_range(0, 1 << 20))) - (1 <<< 19);
            default:
            begin
                it.cur = $signed(48'($urandom_range(0, 32'hFFFFFFFF)));
                it.cur = it.cur <<< $urandom_range(0, 12);
                if ($urandom_range(0, 1))
                    it.cur = -it.cur;
            end
        endcase
        return it;
    endfunction

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        drive_item_t it;
        logic [31:0] gs[4];
        logic signed [47:0] cs[6];
        rst_n = 0;
        stimulus_done = 0;
        gs = '{32'd0, 32'hFFFFFFFF, 32'd1 << 24, 32'd1};
        cs = '{48'sd0, 48'sh7FFFFFFFFFFF, 48'sh800000000000, 48'sd1 <<< 32,
               -(48'sd1 <<< 32), 48'sd175};
        for (int i = 0; i < 24; i++)
        begin
            it.g = gs[i % 4];
            it.cur = cs[i % 6];
            it.nd = 2'(i % 4);
            pending_items.push_back(it);
        end
        for (int i = 0; i < 800; i++)
            pending_items.push_back(random_item());
        repeat (10) @(posedge clk);
        rst_n <= 1;
        wait (pending_items.size() == 0);
        stimulus_done = 1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            conductance <= 0;
            drive_current <= 0;
            negative_diodes <= 0;
            in_gap = 0;
            stored_voltage = 0;
            fallback_seen = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_solutions.push_back(solve_node(pending_items.pop_front()));
                in_gap = random_gap();
            end
            if (!(in_valid && in_stall))
            begin
                if (in_gap == 0 && pending_items.size() > 0)
                begin
                    in_valid <= 1;
                    conductance <= pending_items[0].g;
                    drive_current <= pending_items[0].cur;
                    negative_diodes <= pending_items[0].nd;
                end
                else
                begin
                    in_valid <= 0;
                    if (in_gap > 0)
                        in_gap--;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        solution_t want;
        if (!rst_n)
        begin
            out_stall <= 0;
            out_gap = 0;
            error_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_solutions.size() == 0)
                begin
                    $display("%0t: unexpected item v=%0d", $time, node_voltage);
                    error_count++;
                end
                else
                begin
                    want = expected_solutions.pop_front();
                    if (node_voltage !== want.v)
                    begin
                        $display("%0t: node_voltage expected %0d actual %0d",
                                 $time, want.v, node_voltage);
                        error_count++;
                    end
                    if (final_residual !== want.r)
                    begin
                        $display("%0t: final_residual expected %0d actual %0d",
                                 $time, want.r, final_residual);
                        error_count++;
                    end
                    if (used_bisection !== want.bis)
                    begin
                        $display("%0t: used_bisection expected %0d actual %0d",
                                 $time, want.bis, used_bisection);
                        error_count++;
                    end
                    if (fallback_total !== want.total)
                    begin
                        $display("%0t: fallback_total expected %0d actual %0d",
                                 $time, want.total, fallback_total);
                        error_count++;
                    end
                end
                out_gap = random_gap();
            end
            if (out_gap > 0)
            begin
                out_stall <= 1;
                out_gap--;
            end
            else
                out_stall <= 0;
        end
    end

    initial
    begin
        wait (stimulus_done);
        wait (expected_solutions.size() == 0);
        repeat (200) @(posedge clk);
        if (error_count == 0 && expected_solutions.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #200000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
